### hdl/ascii_command_number_decoder_top_defines.svh
// Assertion macros shared by the command number decoder modules
`ifndef ASCII_COMMAND_NUMBER_DECODER_TOP_DEFINES_SVH
`define ASCII_COMMAND_NUMBER_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ACND_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ACND_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ACND_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ACND_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### hdl/acnd_pkg.sv
// Shared types and constants of the command number decoder
package acnd_pkg;

    localparam int MANT_W  = 64;
    localparam int EXP_W   = 8;
    localparam int SCALE_W = 10;

    localparam logic [15:0] MAG_BIG = 16'd40000;

    typedef struct packed {
        logic                      is_p2;
        logic                      neg;
        logic [MANT_W-1:0]         mant;
        logic [EXP_W-1:0]          exp;
        logic                      exp_neg;
        logic signed [SCALE_W-1:0] scale;
    } t_job;

    function automatic logic [MANT_W-1:0] f_pow10(input int n);
        logic [MANT_W-1:0] p;
        p = 64'd1;
        for (int i = 0; i < n && i < 19; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

### hdl/acnd_fifo.sv
// Two-entry request queue between the character parser and the evaluator
`include "ascii_command_number_decoder_top_defines.svh"
module acnd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acnd_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output acnd_pkg::t_job  o_job
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    acnd_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `ACND_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `ACND_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

### hdl/acnd_front.sv
// Character parser: header match, number syntax and digit accumulation
module acnd_front #(
    parameter int MAX_FRAME       = 256,
    parameter int MANTISSA_DIGITS = 18,
    parameter int EXPONENT_MAX    = 99
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    input  logic           i_full,
    output logic           o_push,
    output acnd_pkg::t_job o_job
);

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam logic [POS_W-1:0] POS_END = POS_W'(MAX_FRAME);
    localparam logic [acnd_pkg::MANT_W-1:0] ROOM_LIM = acnd_pkg::f_pow10(MANTISSA_DIGITS - 1);
    localparam logic [11:0] EXP_CAP = 12'(EXPONENT_MAX);
    localparam logic signed [acnd_pkg::SCALE_W-1:0] SCALE_MAX = 10'sd255;
    localparam logic signed [acnd_pkg::SCALE_W-1:0] SCALE_MIN = -10'sd256;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_E_LO  = 8'h65;

    localparam logic [1:0] HDR_NONE = 2'd0;
    localparam logic [1:0] HDR_P1   = 2'd1;
    localparam logic [1:0] HDR_P2   = 2'd2;
    localparam logic [1:0] HDR_P    = 2'd3;

    localparam logic [2:0] PH_WAIT_EQ  = 3'd0;
    localparam logic [2:0] PH_LEAD     = 3'd1;
    localparam logic [2:0] PH_INT      = 3'd2;
    localparam logic [2:0] PH_FRAC     = 3'd3;
    localparam logic [2:0] PH_EXP_LEAD = 3'd4;
    localparam logic [2:0] PH_EXP      = 3'd5;
    localparam logic [2:0] PH_DONE     = 3'd6;
    localparam logic [2:0] PH_DEAD     = 3'd7;

    logic [POS_W-1:0]                        r_pos,     n_pos;
    logic [1:0]                              r_hdr,     n_hdr;
    logic [2:0]                              r_phase,   n_phase;
    logic                                    r_neg,     n_neg;
    logic [acnd_pkg::MANT_W-1:0]             r_mant,    n_mant;
    logic signed [acnd_pkg::SCALE_W-1:0]     r_scale,   n_scale;
    logic [acnd_pkg::EXP_W-1:0]              r_exp,     n_exp;
    logic                                    r_exp_neg, n_exp_neg;

    logic                        w_acc;
    logic                        w_active;
    logic                        w_digit;
    logic                        w_is_e;
    logic                        w_space;
    logic [3:0]                  w_dval;
    logic                        w_room;
    logic [acnd_pkg::MANT_W-1:0] w_mant10;
    logic [11:0]                 w_exp10;
    logic                        w_mdig;
    logic                        w_frac;
    logic                        w_edig;

    assign o_ready  = !i_full;
    assign w_acc    = i_valid && !i_full;
    assign w_active = (r_pos < POS_END) && (r_phase != PH_DEAD);
    assign w_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_is_e   = (i_char == CH_E_LO) || (i_char == CH_E_UP);
    assign w_space  = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign w_dval   = i_char[3:0];
    assign w_room   = r_mant < ROOM_LIM;
    assign w_mant10 = (r_mant << 3) + (r_mant << 1) + {{(acnd_pkg::MANT_W-4){1'b0}}, w_dval};
    assign w_exp10  = ({4'd0, r_exp} << 3) + ({4'd0, r_exp} << 1) + {8'd0, w_dval};

    always_comb begin
        n_pos     = r_pos;
        n_hdr     = r_hdr;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_mant    = r_mant;
        n_scale   = r_scale;
        n_exp     = r_exp;
        n_exp_neg = r_exp_neg;
        w_mdig    = 1'b0;
        w_frac    = 1'b0;
        w_edig    = 1'b0;
        if (w_active) begin
            if (i_char == CH_NUL) begin
                n_phase = (r_phase == PH_WAIT_EQ) ? PH_DEAD : PH_DONE;
                n_pos   = POS_END;
            end else begin
                if (r_pos == '0) begin
                    n_hdr = (i_char == CH_P) ? HDR_P : HDR_NONE;
                end else if (r_pos == POS_W'(1)) begin
                    if (r_hdr == HDR_P && i_char == CH_ONE) begin
                        n_hdr = HDR_P1;
                    end else if (r_hdr == HDR_P && i_char == CH_TWO) begin
                        n_hdr = HDR_P2;
                    end else begin
                        n_hdr = HDR_NONE;
                    end
                end
                unique case (r_phase)
                    PH_WAIT_EQ: begin
                        if (i_char == CH_EQ) begin
                            n_phase = PH_LEAD;
                        end
                    end
                    PH_LEAD: begin
                        if (w_space) begin
                            n_phase = PH_LEAD;
                        end else if (i_char == CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_INT;
                        end else if (i_char == CH_PLUS) begin
                            n_phase = PH_INT;
                        end else if (w_digit) begin
                            w_mdig  = 1'b1;
                            n_phase = PH_INT;
                        end else if (i_char == CH_DOT) begin
                            n_phase = PH_FRAC;
                        end else if (w_is_e) begin
                            n_phase = PH_EXP_LEAD;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_INT: begin
                        if (w_digit) begin
                            w_mdig = 1'b1;
                        end else if (i_char == CH_DOT) begin
                            n_phase = PH_FRAC;
                        end else if (w_is_e) begin
                            n_phase = PH_EXP_LEAD;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_FRAC: begin
                        if (w_digit) begin
                            w_mdig = 1'b1;
                            w_frac = 1'b1;
                        end else if (w_is_e) begin
                            n_phase = PH_EXP_LEAD;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_EXP_LEAD: begin
                        if (i_char == CH_MINUS) begin
                            n_exp_neg = 1'b1;
                            n_phase   = PH_EXP;
                        end else if (i_char == CH_PLUS) begin
                            n_phase = PH_EXP;
                        end else if (w_digit) begin
                            w_edig  = 1'b1;
                            n_phase = PH_EXP;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_EXP: begin
                        if (w_digit) begin
                            w_edig = 1'b1;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
                n_pos = r_pos + 1'b1;
            end
        end
        if (w_mdig) begin
            if (w_frac) begin
                if (w_room && r_scale < SCALE_MAX) begin
                    n_mant  = w_mant10;
                    n_scale = r_scale + 10'sd1;
                end
            end else if (w_room) begin
                n_mant = w_mant10;
            end else if (r_scale > SCALE_MIN) begin
                n_scale = r_scale - 10'sd1;
            end
        end
        if (w_edig) begin
            n_exp = (w_exp10 > EXP_CAP) ? EXP_CAP[acnd_pkg::EXP_W-1:0]
                                        : w_exp10[acnd_pkg::EXP_W-1:0];
        end
    end

    assign o_push = w_acc && i_last && (n_phase != PH_WAIT_EQ) && (n_phase != PH_DEAD)
                    && ((n_hdr == HDR_P1) || (n_hdr == HDR_P2));

    always_comb begin
        o_job.is_p2   = (n_hdr == HDR_P2);
        o_job.neg     = n_neg;
        o_job.mant    = n_mant;
        o_job.exp     = n_exp;
        o_job.exp_neg = n_exp_neg;
        o_job.scale   = n_scale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_last)) begin
            r_pos     <= '0;
            r_hdr     <= HDR_NONE;
            r_phase   <= PH_WAIT_EQ;
            r_neg     <= 1'b0;
            r_mant    <= '0;
            r_scale   <= '0;
            r_exp     <= '0;
            r_exp_neg <= 1'b0;
        end else if (w_acc) begin
            r_pos     <= n_pos;
            r_hdr     <= n_hdr;
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_mant    <= n_mant;
            r_scale   <= n_scale;
            r_exp     <= n_exp;
            r_exp_neg <= n_exp_neg;
        end
    end

endmodule

### hdl/acnd_back.sv
// Evaluator: decimal scaling, truncation, command mapping and output register
`include "ascii_command_number_decoder_top_defines.svh"
module acnd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  acnd_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_command,
    output logic                o_run,
    output logic signed [15:0]  o_speed,
    output logic                o_clip
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [acnd_pkg::MANT_W-1:0] BIG_W = {48'd0, acnd_pkg::MAG_BIG};

    function automatic logic [7:0] f_div_step(input logic [3:0] rem, input logic [3:0] nib);
        logic [4:0] t;
        logic [3:0] r;
        logic [3:0] q;
        r = rem;
        q = 4'd0;
        for (int i = 3; i >= 0; i--) begin
            t = {r, nib[i]};
            if (t >= 5'd10) begin
                r    = 4'(t - 5'd10);
                q[i] = 1'b1;
            end else begin
                r    = t[3:0];
                q[i] = 1'b0;
            end
        end
        return {q, r};
    endfunction

    logic [2:0]                  r_state;
    logic [acnd_pkg::MANT_W-1:0] r_work;
    logic signed [10:0]          r_e;
    logic                        r_is_p2;
    logic                        r_neg;
    logic [4:0]                  r_cnt;
    logic [3:0]                  r_nib;
    logic [3:0]                  r_rem;
    logic [7:0]                  r_res;
    logic [15:0]                 r_mag;
    logic                        r_out_valid;
    logic                        r_out_cmd;
    logic                        r_out_run;
    logic [15:0]                 r_out_speed;
    logic                        r_out_clip;

    logic signed [10:0] w_exp_s;
    logic signed [10:0] w_e;
    logic [10:0]        w_k;
    logic [19:0]        w_mag10;
    logic [7:0]         w_step;
    logic [15:0]        w_work_mag;
    logic               w_load_out;
    logic               w_run;
    logic [15:0]        w_speed;
    logic               w_clip;

    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign w_exp_s    = {3'd0, i_job.exp};
    assign w_e        = (i_job.exp_neg ? -w_exp_s : w_exp_s) - {i_job.scale[9], i_job.scale};
    assign w_k        = 11'(-r_e);
    assign w_mag10    = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1);
    assign w_step     = f_div_step(r_rem, r_work[63:60]);
    assign w_work_mag = (r_work > BIG_W) ? acnd_pkg::MAG_BIG : r_work[15:0];
    assign w_load_out = (r_state == ST_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        w_run   = 1'b0;
        w_speed = 16'd0;
        w_clip  = 1'b0;
        if (!r_is_p2) begin
            w_run = !r_neg && (r_res == 8'd1);
        end else if (r_neg) begin
            if (r_mag > 16'd32768) begin
                w_speed = 16'h8000;
                w_clip  = 1'b1;
            end else begin
                w_speed = 16'd0 - r_mag;
            end
        end else begin
            if (r_mag > 16'd32767) begin
                w_speed = 16'h7FFF;
                w_clip  = 1'b1;
            end else begin
                w_speed = r_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_state <= r_e[10] ? ST_DIV : ST_MUL;
                end
                ST_MUL: begin
                    if (r_cnt == 5'd0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_DIV: begin
                    if (r_nib == 4'd0 && (r_cnt == 5'd0 || r_work == '0)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_work  <= i_job.mant;
                    r_e     <= w_e;
                    r_is_p2 <= i_job.is_p2;
                    r_neg   <= i_job.neg;
                end
            end
            ST_LOAD: begin
                r_nib <= 4'd0;
                r_rem <= 4'd0;
                if (!r_e[10]) begin
                    r_cnt <= (r_e > 11'sd8) ? 5'd8 : r_e[4:0];
                    r_mag <= w_work_mag;
                    r_res <= r_work[7:0];
                end else if (w_k >= 11'd20) begin
                    r_work <= '0;
                    r_cnt  <= 5'd0;
                end else begin
                    r_cnt <= w_k[4:0];
                end
            end
            ST_MUL: begin
                if (r_cnt != 5'd0) begin
                    r_res <= 8'(({r_res, 3'd0}) + ({r_res, 1'b0}));
                    r_mag <= (w_mag10 > {4'd0, acnd_pkg::MAG_BIG}) ? acnd_pkg::MAG_BIG
                                                                  : w_mag10[15:0];
                    r_cnt <= r_cnt - 5'd1;
                end
            end
            ST_DIV: begin
                if (r_nib == 4'd0 && (r_cnt == 5'd0 || r_work == '0)) begin
                    r_res <= r_work[7:0];
                    r_mag <= w_work_mag;
                end else begin
                    r_work <= {r_work[59:0], w_step[7:4]};
                    r_nib  <= r_nib + 4'd1;
                    if (r_nib == 4'd15) begin
                        r_rem <= 4'd0;
                        r_cnt <= r_cnt - 5'd1;
                    end else begin
                        r_rem <= w_step[3:0];
                    end
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_cmd   <= r_is_p2;
            r_out_run   <= w_run;
            r_out_speed <= w_speed;
            r_out_clip  <= w_clip;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_command = r_out_cmd;
    assign o_run     = r_out_run;
    assign o_speed   = r_out_speed;
    assign o_clip    = r_out_clip;

    `ACND_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_state == ST_DIV, r_rem < 4'd10, "remainder out of range")
    `ACND_ASSERT_IMP(a_mag_cap, i_clk, i_rst_n, r_state == ST_MUL, r_mag <= acnd_pkg::MAG_BIG, "magnitude above cap")
    `ACND_ASSERT_NXT(a_pop_load, i_clk, i_rst_n, o_pop, r_state == ST_LOAD, "pop did not start evaluation")

endmodule

### hdl/ascii_command_number_decoder_top.sv
// Top level of the ASCII command number decoder
//
//  channel   dir  tdata (low bit first)                      tuser     tlast
//  s_axis    in   char_byte[7:0]                             -         frame_end
//  m_axis    out  run_request, speed_ref[15:0], clipped, pad  command   -
//
//  One character is taken per cycle while the queue is not full.
//  At a frame end a request enters a two-entry queue; the evaluator drains it by
//  scaling the mantissa up by ten min(e, 8) times for a non-negative decimal exponent e,
//  or dividing it by ten k times for a negative exponent -k (k up to 19, larger k gives
//  zero) in a nibble-serial divide-by-ten loop. s_axis_tready drops only while the queue is full.
//  Reset is synchronous, active low, and clears parser, queue and evaluator control.
module ascii_command_number_decoder_top #(
    parameter int MAX_FRAME       = 256,
    parameter int MANTISSA_DIGITS = 18,
    parameter int EXPONENT_MAX    = 99
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] run_request, [16:1] speed_ref, [17] clipped
    output logic        m_axis_tuser    // [0] command
);

    acnd_pkg::t_job     w_push_job;
    acnd_pkg::t_job     w_pop_job;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    logic               w_run;
    logic signed [15:0] w_speed;
    logic               w_clip;

    acnd_front #(
        .MAX_FRAME       (MAX_FRAME),
        .MANTISSA_DIGITS (MANTISSA_DIGITS),
        .EXPONENT_MAX    (EXPONENT_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    acnd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_pop_job)
    );

    acnd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_job     (w_pop_job),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_command (m_axis_tuser),
        .o_run     (w_run),
        .o_speed   (w_speed),
        .o_clip    (w_clip)
    );

    assign m_axis_tdata = {6'd0, w_clip, w_speed, w_run};

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for the ASCII command number decoder: directed and random frames checked against a predictor
module testbench;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_FRAME    = 256;
    localparam int MANT_DIGITS  = 18;
    localparam int EXP_LIMIT    = 99;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_CHARS = 160;

    localparam logic [63:0] MAG_CAP = 64'd40000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_E_LO  = 8'h65;

    typedef enum logic [1:0] {HDR_NONE, HDR_P1, HDR_P2, HDR_P_ONLY} header_e;

    typedef enum logic [3:0] {
        AWAIT_EQ, LEAD, INT_PART, FRAC_PART, EXP_LEAD, EXP_DIGITS, NUM_DONE, STR_DEAD
    } num_phase_e;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_THREE_OF_FOUR, RDY_MOSTLY} stall_e;

    typedef struct packed {
        logic        command;
        logic        run_request;
        logic [15:0] speed_ref;
        logic        clipped;
    } decoded_cmd_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    decoded_cmd_t pending_cmds[$];
    logic [7:0]   frame_chars[$];

    int unsigned char_count;
    header_e     hdr;
    num_phase_e  phase;
    bit          val_neg;
    logic [63:0] digits;
    int          scale;
    int unsigned exp_mag;
    bit          exp_neg;

    int errors      = 0;
    int burst_left  = 0;
    int gap_max     = 8;
    int chars_sent  = 0;
    int idle_cycles = 0;
    bit hold_off_req = 1'b0;

    ascii_command_number_decoder_top #(
        .MAX_FRAME       (MAX_FRAME),
        .MANTISSA_DIGITS (MANT_DIGITS),
        .EXPONENT_MAX    (EXP_LIMIT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [63:0] pow10_of(int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n && i < 19; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    function automatic void clear_parser();
        char_count = 0;
        hdr        = HDR_NONE;
        phase      = AWAIT_EQ;
        val_neg    = 1'b0;
        digits     = 64'd0;
        scale      = 0;
        exp_mag    = 0;
        exp_neg    = 1'b0;
    endfunction

    function automatic void take_digit(int d, bit frac);
        bit room;
        room = digits < pow10_of(MANT_DIGITS - 1);
        if (frac) begin
            if (room && scale < 255) begin
                digits = digits * 64'd10 + 64'(d);
                scale++;
            end
        end else if (room) begin
            digits = digits * 64'd10 + 64'(d);
        end else if (scale > -256) begin
            scale--;
        end
    endfunction

    function automatic void take_exp_digit(int d);
        int unsigned v;
        v = exp_mag * 10 + d;
        exp_mag = (v > EXP_LIMIT) ? EXP_LIMIT : v;
    endfunction

    function automatic void scan_number(logic [7:0] c);
        bit is_e   = (c == CH_E_LO) || (c == CH_E_UP);
        bit is_num = (c >= CH_ZERO) && (c <= CH_NINE);
        bit is_ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        int d      = int'(c) - int'(CH_ZERO);
        case (phase)
            AWAIT_EQ: begin
                if (c == CH_EQ) phase = LEAD;
            end
            LEAD: begin
                if (!is_ws) begin
                    if (c == CH_MINUS) begin
                        val_neg = 1'b1;
                        phase = INT_PART;
                    end else if (c == CH_PLUS) begin
                        phase = INT_PART;
                    end else if (is_num) begin
                        take_digit(d, 1'b0);
                        phase = INT_PART;
                    end else if (c == CH_DOT) begin
                        phase = FRAC_PART;
                    end else if (is_e) begin
                        phase = EXP_LEAD;
                    end else begin
                        phase = NUM_DONE;
                    end
                end
            end
            INT_PART: begin
                if (is_num) take_digit(d, 1'b0);
                else if (c == CH_DOT) phase = FRAC_PART;
                else if (is_e) phase = EXP_LEAD;
                else phase = NUM_DONE;
            end
            FRAC_PART: begin
                if (is_num) take_digit(d, 1'b1);
                else if (is_e) phase = EXP_LEAD;
                else phase = NUM_DONE;
            end
            EXP_LEAD: begin
                if (c == CH_MINUS) begin
                    exp_neg = 1'b1;
                    phase = EXP_DIGITS;
                end else if (c == CH_PLUS) begin
                    phase = EXP_DIGITS;
                end else if (is_num) begin
                    take_exp_digit(d);
                    phase = EXP_DIGITS;
                end else begin
                    phase = NUM_DONE;
                end
            end
            EXP_DIGITS: begin
                if (is_num) take_exp_digit(d);
                else phase = NUM_DONE;
            end
            default: ;
        endcase
    endfunction

    function automatic void close_frame();
        int           e;
        logic [63:0]  mag;
        logic [63:0]  res;
        logic [63:0]  q;
        decoded_cmd_t r;
        if (phase == AWAIT_EQ || phase == STR_DEAD) return;
        if (hdr != HDR_P1 && hdr != HDR_P2) return;
        e = exp_neg ? -int'(exp_mag) : int'(exp_mag);
        e = e - scale;
        mag = 64'd0;
        res = 64'd0;
        if (digits != 64'd0) begin
            if (e >= 0) begin
                res = (e >= 8) ? 64'd0 : (((digits & 64'd255) * pow10_of(e)) & 64'd255);
                if (e >= 5 || digits > MAG_CAP) begin
                    mag = MAG_CAP;
                end else begin
                    mag = digits * pow10_of(e);
                    if (mag > MAG_CAP) mag = MAG_CAP;
                end
            end else if (-e < 20) begin
                q = digits / pow10_of(-e);
                res = q & 64'd255;
                mag = (q > MAG_CAP) ? MAG_CAP : q;
            end
        end
        r = '0;
        if (hdr == HDR_P1) begin
            r.run_request = !val_neg && (res == 64'd1);
        end else begin
            r.command = 1'b1;
            if (val_neg) begin
                if (mag > 64'd32768) begin
                    mag = 64'd32768;
                    r.clipped = 1'b1;
                end
                r.speed_ref = -mag[15:0];
            end else begin
                if (mag > 64'd32767) begin
                    mag = 64'd32767;
                    r.clipped = 1'b1;
                end
                r.speed_ref = mag[15:0];
            end
        end
        pending_cmds.push_back(r);
    endfunction

    function automatic void model_char(logic [7:0] c, bit last);
        if (char_count < MAX_FRAME && phase != STR_DEAD) begin
            if (c == CH_NUL) begin
                phase = (phase == AWAIT_EQ) ? STR_DEAD : NUM_DONE;
                char_count = MAX_FRAME;
            end else begin
                if (char_count == 0) begin
                    hdr = (c == CH_P) ? HDR_P_ONLY : HDR_NONE;
                end else if (char_count == 1) begin
                    if (hdr == HDR_P_ONLY && c == CH_ONE) hdr = HDR_P1;
                    else if (hdr == HDR_P_ONLY && c == CH_TWO) hdr = HDR_P2;
                    else hdr = HDR_NONE;
                end
                scan_number(c);
                char_count++;
            end
        end
        if (last) begin
            close_frame();
            clear_parser();
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] error: %s", $time, what);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_results
        decoded_cmd_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cmds.size() == 0) begin
                report_mismatch("result arrived with nothing pending");
            end else begin
                want = pending_cmds.pop_front();
                if (m_axis_tuser !== want.command)
                    report_mismatch($sformatf("command got %0b want %0b",
                                              m_axis_tuser, want.command));
                if (m_axis_tdata[0] !== want.run_request)
                    report_mismatch($sformatf("run_request got %0b want %0b",
                                              m_axis_tdata[0], want.run_request));
                if (m_axis_tdata[16:1] !== want.speed_ref)
                    report_mismatch($sformatf("speed_ref got %0d want %0d",
                                              $signed(m_axis_tdata[16:1]),
                                              $signed(want.speed_ref)));
                if (m_axis_tdata[17] !== want.clipped)
                    report_mismatch($sformatf("clipped got %0b want %0b",
                                              m_axis_tdata[17], want.clipped));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ascii_command_number_decoder_top: mismatch");
                $finish;
            end
        end
    end

    initial begin : stall_pattern
        stall_e mode;
        int     left;
        int     tick;
        mode = RDY_ALWAYS;
        left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = stall_e'($urandom_range(0, 3));
                    left = $urandom_range(20, 200);
                end
                left--;
                tick++;
                case (mode)
                    RDY_ALWAYS:        m_axis_tready <= 1'b1;
                    RDY_COIN:          m_axis_tready <= 1'($urandom_range(0, 1));
                    RDY_THREE_OF_FOUR: m_axis_tready <= (tick % 4) != 0;
                    default:           m_axis_tready <= $urandom_range(0, 9) != 0;
                endcase
            end
        end
    end

    task automatic send_char(logic [7:0] c, bit last);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model_char(c, last);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_chars[i]) send_char(frame_chars[i], i == frame_chars.size() - 1);
    endtask

    function automatic void add_text(string s);
        foreach (s[i]) frame_chars.push_back(s[i]);
    endfunction

    task automatic send_text(string s);
        frame_chars.delete();
        add_text(s);
        send_frame();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() > 0) @(posedge i_clk);
    endtask

    function automatic void add_digits(int n);
        repeat (n) frame_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    task automatic build_random_frame();
        int n;
        bit is_p1;
        frame_chars.delete();
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 12);
            repeat (n) frame_chars.push_back(8'($urandom));
            return;
        end
        n = $urandom_range(0, 19);
        is_p1 = n < 9;
        if (is_p1) begin
            add_text("P1");
        end else if (n < 18) begin
            add_text("P2");
        end else begin
            case ($urandom_range(0, 3))
                0: add_text("P");
                1: add_text("P3");
                2: add_text("Q2");
                default: add_text("p1");
            endcase
        end
        if ($urandom_range(0, 9) == 0) frame_chars.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 19) != 0) frame_chars.push_back(CH_EQ);
        n = $urandom_range(0, 6);
        if (n < 3) begin
            repeat (n) begin
                if ($urandom_range(0, 1) == 0) frame_chars.push_back(CH_SPACE);
                else frame_chars.push_back(CH_TAB + 8'($urandom_range(0, 4)));
            end
        end
        case ($urandom_range(0, 3))
            0: frame_chars.push_back(CH_MINUS);
            1: frame_chars.push_back(CH_PLUS);
            default: ;
        endcase
        if (is_p1 && $urandom_range(0, 9) < 4) begin
            add_text($sformatf("%0d", $urandom_range(0, 3) * 256 + 1));
        end else if ($urandom_range(0, 15) == 0) begin
            add_digits($urandom_range(7, 24));
        end else begin
            add_digits($urandom_range(0, 6));
        end
        if ($urandom_range(0, 2) == 0) begin
            frame_chars.push_back(CH_DOT);
            add_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 3) == 0) begin
            frame_chars.push_back($urandom_range(0, 1) ? CH_E_UP : CH_E_LO);
            case ($urandom_range(0, 2))
                0: frame_chars.push_back(CH_MINUS);
                1: frame_chars.push_back(CH_PLUS);
                default: ;
            endcase
            add_digits($urandom_range(0, 2));
        end
        if ($urandom_range(0, 2) == 0) frame_chars.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 19) == 0)
            frame_chars.insert($urandom_range(0, frame_chars.size() - 1), CH_NUL);
    endtask

    task automatic test_run_commands();
        send_text("P1=1");
        send_text("P1=257");
        send_text("P1=-1");
        send_text("P1= +1.99");
        send_text("P1=2");
        send_text("P1=0.01e2");
        send_text("P1=0");
        send_text("P1=-257");
    endtask

    task automatic test_speed_refs();
        send_text("P2=32767");
        send_text("P2=32768");
        send_text("P2=-32768");
        send_text("P2=-32769");
        send_text("P2=-40001");
        send_text("P2=1e99");
        send_text("P2=1e999");
        send_text("P2=123456789012345678901234");
        send_text("P2=0.123456789012345678901e5");
        send_text("P2=9.999e3");
        send_text("P2=\t-12.5E1");
        send_text("P2=5E-3");
        send_text("P2=1e-19");
        send_text("P2=65537e-1");
    endtask

    task automatic test_number_syntax();
        send_text("P2=");
        send_text("P2=.");
        send_text("P2=abc");
        send_text("P2=+");
        send_text("P2=3e");
        send_text("P2=4e+2");
        send_text("P2=-e5");
        send_text("P2=\v\f\n 8x9");
        send_text("P2=12=34");
        send_text("P2=1.2.3");
    endtask

    task automatic test_no_result_frames();
        send_text("P3=5");
        send_text("P=5");
        send_text("p1=5");
        send_text("X");
        send_text("P2 5");
        send_text("P1");
        send_text("1=P1");
    endtask

    task automatic test_string_end();
        frame_chars.delete();
        add_text("P1");
        frame_chars.push_back(CH_NUL);
        add_text("=1");
        send_frame();
        frame_chars.delete();
        add_text("P2=7");
        frame_chars.push_back(CH_NUL);
        add_text("99");
        send_frame();
        frame_chars.delete();
        frame_chars.push_back(CH_NUL);
        send_frame();
        frame_chars.delete();
        frame_chars.push_back(CH_NUL);
        add_text("P2=5");
        send_frame();
    endtask

    task automatic test_overlong_frame();
        frame_chars.delete();
        add_text("P2=");
        repeat (MANT_DIGITS + 8) frame_chars.push_back(CH_NINE);
        send_frame();
        frame_chars.delete();
        add_text("P1=");
        while (frame_chars.size() < MAX_FRAME - 1) frame_chars.push_back(CH_ZERO);
        frame_chars.push_back(CH_ONE);
        add_text("0000");
        send_frame();
    endtask

    task automatic test_backpressure();
        gap_max = 0;
        hold_off_req = 1'b1;
        repeat (8) send_text("P1=1");
        repeat (4) send_text("P2=-3");
        drain();
        gap_max = 8;
    endtask

    task automatic test_random_frames();
        int start;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS) begin
            if ($urandom_range(0, 9) == 0) gap_max = ($urandom_range(0, 1) == 0) ? 0 : 8;
            build_random_frame();
            send_frame();
            if ($urandom_range(0, 49) == 0) drain();
        end
    endtask

    initial begin
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_run_commands();
        test_speed_refs();
        test_number_syntax();
        test_no_result_frames();
        test_string_end();
        test_overlong_frame();
        test_backpressure();
        test_random_frames();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ascii_command_number_decoder_top: match");
        end else begin
            $display("ascii_command_number_decoder_top: mismatch");
        end
        $finish;
    end

endmodule
